[rtl/nme_pkg.sv]
// Shared constants and types for the NAF modular exponentiation block.
// No dependencies.
`default_nettype none
package nme_pkg;
    localparam int WIDTH = 32;
    localparam int DW = 32;
    localparam int CW = $clog2(WIDTH + 2);

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_MODB  = 3'd2,
        OP_MULA  = 3'd3,
        OP_INV   = 3'd4,
        OP_MULI  = 3'd5,
        OP_SQR   = 3'd6
    } t_op;

    typedef struct packed {
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic digit_nz;
        logic digit_neg;
        logic last;
        logic m_small;
    } t_sts;
endpackage
`default_nettype wire

[rtl/nme_ctrl.sv]
// Controller state machine for the NAF exponentiation block.
// Depends on nme_pkg.
`default_nettype none
module nme_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  nme_pkg::t_sts  i_sts,
    output nme_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);
    typedef enum logic [2:0] {
        S_IDLE, S_MODB, S_DIG, S_MULI, S_SQR, S_WAIT, S_OUT
    } t_state;

    t_state r_state;
    t_state r_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            o_cmd   <= '{op: nme_pkg::OP_NONE};
            o_busy  <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    o_cmd  <= '{op: i_start ? nme_pkg::OP_LOAD : nme_pkg::OP_NONE};
                    o_done <= 1'b0;
                    if (i_start) begin
                        o_busy  <= 1'b1;
                        r_state <= S_MODB;
                    end
                end
                S_MODB: begin
                    o_cmd   <= '{op: nme_pkg::OP_MODB};
                    o_done  <= 1'b0;
                    r_ret   <= S_DIG;
                    r_state <= S_WAIT;
                end
                S_DIG: begin
                    o_done <= 1'b0;
                    if (i_sts.m_small) begin
                        o_cmd   <= '{op: nme_pkg::OP_NONE};
                        r_state <= S_OUT;
                    end else if (i_sts.digit_nz && i_sts.digit_neg) begin
                        o_cmd   <= '{op: nme_pkg::OP_INV};
                        r_ret   <= S_MULI;
                        r_state <= S_WAIT;
                    end else if (i_sts.digit_nz) begin
                        o_cmd   <= '{op: nme_pkg::OP_MULA};
                        r_ret   <= S_SQR;
                        r_state <= S_WAIT;
                    end else begin
                        o_cmd   <= '{op: nme_pkg::OP_NONE};
                        r_state <= S_SQR;
                    end
                end
                S_MULI: begin
                    o_cmd   <= '{op: nme_pkg::OP_MULI};
                    o_done  <= 1'b0;
                    r_ret   <= S_SQR;
                    r_state <= S_WAIT;
                end
                S_SQR: begin
                    o_cmd   <= '{op: nme_pkg::OP_SQR};
                    o_done  <= 1'b0;
                    r_ret   <= i_sts.last ? S_OUT : S_DIG;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    o_cmd  <= '{op: nme_pkg::OP_NONE};
                    o_done <= 1'b0;
                    if (i_sts.done && o_cmd.op == nme_pkg::OP_NONE) r_state <= r_ret;
                end
                S_OUT: begin
                    o_cmd   <= '{op: nme_pkg::OP_NONE};
                    o_done  <= 1'b1;
                    o_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    o_cmd   <= '{op: nme_pkg::OP_NONE};
                    o_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/nme_dp.sv]
// Datapath: operand registers, NAF recoder, shift-add modular multiplier,
// restoring divider and extended Euclid sequencer. Depends on nme_pkg.
`default_nettype none
module nme_dp (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  nme_pkg::t_cmd           i_cmd,
    input  wire [nme_pkg::DW-1:0]   i_base_value,
    input  wire [nme_pkg::DW-1:0]   i_exponent_value,
    input  wire [nme_pkg::DW-1:0]   i_modulus,
    output nme_pkg::t_sts           o_sts,
    output logic [nme_pkg::DW-1:0]  o_result
);
    localparam int DW = nme_pkg::DW;
    localparam int CW = nme_pkg::CW;
    localparam int BW = $clog2(DW + 1);
    localparam int WIDTHX = nme_pkg::WIDTH + 2;

    typedef enum logic [3:0] {
        U_IDLE, U_MUL, U_MODB, U_IDIV, U_IMUL, U_IUPD, U_IFIN
    } t_unit;

    t_unit r_u;
    logic [DW-1:0] r_m, r_sq, r_acc, r_inv;
    logic [WIDTHX-1:0] r_e;
    logic [CW-1:0] r_i;
    logic          r_carry;
    // multiplier: r_pa accumulator, r_pb multiplicand, r_px multiplier bits
    logic [DW-1:0] r_pa, r_pb, r_px;
    logic [BW-1:0] r_bit;
    logic [1:0]    r_dst;
    // Euclid registers
    logic [DW-1:0] r_r0, r_r1, r_s0, r_s1, r_q, r_rem;
    logic [DW:0]   r_dr;

    logic cur, nxt, ncarry;
    assign cur    = r_e[r_i];
    assign nxt    = r_e[r_i + CW'(1)];
    assign ncarry = (32'(r_carry) + 32'(cur) + 32'(nxt)) >= 32'd2;

    assign o_sts.done      = (r_u == U_IDLE);
    assign o_sts.digit_nz  = r_carry ^ cur;
    assign o_sts.digit_neg = ncarry;
    assign o_sts.last      = (r_i == CW'(nme_pkg::WIDTH));
    assign o_sts.m_small   = (r_m < DW'(2));
    assign o_result        = (r_m < DW'(2)) ? '0 : r_acc;

    // one add-and-reduce step of the interleaved modular multiplier
    logic [DW+1:0] dbl, dsub, add, asub;
    always_comb begin
        dbl  = {1'b0, r_pa, 1'b0};
        dsub = (dbl >= {2'b0, r_m}) ? dbl - {2'b0, r_m} : dbl;
        add  = dsub + (r_px[DW-1] ? {2'b0, r_pb} : '0);
        asub = (add >= {2'b0, r_m}) ? add - {2'b0, r_m} : add;
    end

    // restoring division step
    logic [DW:0] dtry;
    assign dtry = {r_dr[DW-1:0], r_rem[DW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u <= U_IDLE;
        end else begin
            unique case (i_cmd.op)
                nme_pkg::OP_LOAD: begin
                    r_m     <= i_modulus;
                    r_e     <= {2'b0, i_exponent_value[nme_pkg::WIDTH-1:0]};
                    r_i     <= '0;
                    r_carry <= 1'b0;
                    r_acc   <= DW'(1);
                    r_sq    <= i_base_value;
                end
                nme_pkg::OP_MODB: begin
                    // base mod m by long division
                    r_rem <= r_sq; r_dr <= '0; r_q <= '0; r_bit <= '0;
                    r_u <= (r_m < DW'(2)) ? U_IDLE : U_MODB;
                end
                nme_pkg::OP_MULA, nme_pkg::OP_MULI, nme_pkg::OP_SQR: begin
                    r_pa  <= '0;
                    r_pb  <= (i_cmd.op == nme_pkg::OP_MULI) ? r_inv : r_sq;
                    r_px  <= (i_cmd.op == nme_pkg::OP_SQR) ? r_sq : r_acc;
                    r_dst <= (i_cmd.op == nme_pkg::OP_SQR) ? 2'd1 : 2'd0;
                    r_bit <= '0;
                    r_u   <= U_MUL;
                end
                nme_pkg::OP_INV: begin
                    r_r0 <= r_m; r_r1 <= r_sq; r_s0 <= '0; r_s1 <= DW'(1);
                    r_u  <= U_IFIN;
                end
                default: ;
            endcase
            unique case (r_u)
                U_IDLE: ;
                U_MUL: begin
                    r_pa  <= asub[DW-1:0];
                    r_px  <= {r_px[DW-2:0], 1'b0};
                    r_bit <= r_bit + BW'(1);
                    if (r_bit == BW'(DW - 1)) begin
                        r_u <= U_IDLE;
                        if (r_dst == 2'd1) r_sq <= asub[DW-1:0];
                        else begin
                            r_acc   <= asub[DW-1:0];
                        end
                        if (r_dst == 2'd1) begin
                            r_i     <= r_i + CW'(1);
                            r_carry <= ncarry;
                        end
                    end
                end
                U_MODB, U_IDIV: begin
                    if (dtry >= {1'b0, (r_u == U_MODB) ? r_m : r_r1}) begin
                        r_dr <= dtry - {1'b0, (r_u == U_MODB) ? r_m : r_r1};
                        r_q  <= {r_q[DW-2:0], 1'b1};
                    end else begin
                        r_dr <= dtry;
                        r_q  <= {r_q[DW-2:0], 1'b0};
                    end
                    r_rem <= {r_rem[DW-2:0], 1'b0};
                    r_bit <= r_bit + BW'(1);
                    if (r_bit == BW'(DW - 1)) begin
                        if (r_u == U_MODB) begin
                            r_sq <= (dtry >= {1'b0, r_m}) ?
                                    DW'(dtry - {1'b0, r_m}) : dtry[DW-1:0];
                            r_u <= U_IDLE;
                        end else begin
                            r_u <= U_IMUL;
                        end
                    end
                end
                U_IMUL: begin
                    // q may be as large as m; the multiplier reduces as it goes,
                    // so sub = q*s1 mod m without reducing q first.
                    r_pa <= '0; r_pb <= r_s1; r_px <= r_q; r_bit <= '0;
                    r_u  <= U_IUPD;
                    r_dst <= 2'd2;
                end
                U_IUPD: begin
                    if (r_dst == 2'd2) begin
                        r_pa  <= asub[DW-1:0];
                        r_px  <= {r_px[DW-2:0], 1'b0};
                        r_bit <= r_bit + BW'(1);
                        if (r_bit == BW'(DW - 1)) r_dst <= 2'd3;
                    end else begin
                        r_s0 <= r_s1;
                        r_s1 <= (r_s0 >= r_pa) ? r_s0 - r_pa : r_s0 + (r_m - r_pa);
                        r_r0 <= r_r1;
                        r_r1 <= r_dr[DW-1:0];
                        r_u  <= U_IFIN;
                    end
                end
                U_IFIN: begin
                    if (r_r1 == '0) begin
                        r_inv <= (r_r0 == DW'(1)) ? r_s0 : '0;
                        r_u   <= U_IDLE;
                    end else begin
                        r_rem <= r_r0; r_dr <= '0; r_q <= '0; r_bit <= '0;
                        r_u   <= U_IDIV;
                    end
                end
                default: r_u <= U_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/naf_modular_exponentiation.sv]
// Top level of the NAF modular exponentiation block.
// Depends on nme_pkg, nme_ctrl and nme_dp.
`default_nettype none
// Usage: raise start with i_base_value and i_exponent_value; the beat is taken
// at the first rising edge at which busy is low, and the operands are captured
// there, so they need not be held afterwards. The block recodes the exponent
// into WIDTH+1 non-adjacent-form digits, least significant first. A +1 digit
// multiplies the result by the running square, a -1 digit by its inverse from
// an extended Euclidean sequence (zero where none exists), and every digit
// ends by squaring. Multiplies are bit-serial and the Euclid divisions are
// restoring, one bit a cycle each; a -1 digit runs one division and one
// multiply per Euclid step before its own multiply and square.
// One item is in flight at a time; busy falls in the cycle o_done is high, so
// the next beat can be taken at the edge that ends the result cycle.
// The result appears on o_power_result for one cycle with o_done high; the
// receiver cannot stall and must take it then.
// The modulus is written over i_cfg_valid/o_cfg_ready, by the user only while
// idle; the block itself does not enforce this. Reset sets it to 2 and returns
// the controller to idle. A modulus below two gives a zero result.
module naf_modular_exponentiation (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  wire [31:0] i_base_value,
    input  wire [31:0] i_exponent_value,
    output logic       o_done,
    output logic [31:0] o_power_result,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [31:0] i_cfg_modulus
);
    logic [31:0] r_modulus;
    logic [31:0] r_base_value;
    logic [31:0] r_exponent_value;
    nme_pkg::t_cmd cmd;
    nme_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_modulus <= 32'd2;
        else if (i_cfg_valid && o_cfg_ready) r_modulus <= i_cfg_modulus;
    end

    // The operands are held from the accepting edge until the datapath loads them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_value     <= '0;
            r_exponent_value <= '0;
        end else if (start && !busy) begin
            r_base_value     <= i_base_value;
            r_exponent_value <= i_exponent_value;
        end
    end

    nme_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start && !busy),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy), .o_done(o_done)
    );

    nme_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_base_value(r_base_value), .i_exponent_value(r_exponent_value),
        .i_modulus(r_modulus), .o_sts(sts), .o_result(o_power_result)
    );

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("busy during done");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double done");
endmodule
`default_nettype wire
